### rtl/fblrd_pkg.sv
// ----------------------------------------------------------------------------
// fblrd_pkg
// Shared constants, types and helper functions for the framebuffer line and
// rectangle drawer.
// ----------------------------------------------------------------------------
package fblrd_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int PIXEL_BITS = 32;

    localparam int COORD_W   = 12;
    localparam int FRAC_W    = 16;
    localparam int CW        = COORD_W + 2;
    localparam int DW        = COORD_W + 1;
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam int POS_W     = COORD_W + FRAC_W + 1;
    localparam int IP_W      = POS_W - FRAC_W;
    localparam int Q_W       = FRAC_W + 1;
    localparam int INC_W     = Q_W + 1;
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam int CNT_W     = 15;
    localparam int CFG_W     = 8;
    localparam int IDX_W     = 1;
    localparam int FUNC_W    = 2;
    localparam int TD_IN_W   = 4 * COORD_W + PIXEL_BITS;
    localparam int TD_OUT_W  = ((PIXEL_BITS + CNT_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(128);

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LINE = 2'd0,
        FUNC_RECT = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_PLOT = 2'd3
    } func_t;

    typedef logic signed [CW-1:0] coord_t;

    function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
        logic [AW-1:0] row;
        row = AW'(y) * AW'(MAX_WIDTH);
        return row + AW'(x);
    endfunction

    function automatic logic in_bounds(input coord_t x, input coord_t y,
                                       input logic [CW-1:0] vw,
                                       input logic [CW-1:0] vh);
        return !x[CW-1] && ($unsigned(x) < vw) && !y[CW-1] && ($unsigned(y) < vh);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    // Q.16 position to integer pixel, truncated toward zero
    function automatic coord_t q16_trunc(input logic signed [POS_W-1:0] p);
        logic signed [IP_W-1:0] ip;
        ip = p[POS_W-1:FRAC_W];
        if (p[POS_W-1] && (p[FRAC_W-1:0] != '0)) begin
            ip = ip + IP_W'(1);
        end
        return coord_t'(ip);
    endfunction

endpackage

### rtl/framebuffer_line_rect_drawer_core.sv
// ----------------------------------------------------------------------------
// framebuffer_line_rect_drawer_core
// DDA line, rectangle fill, pixel plot and pixel read over a 32-bit
// framebuffer held in one synchronous single-port memory, clipped to the
// configured visible size.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid / s_tready   s_tuser = func; s_tdata = coords, color
// m_       out  m_tvalid / m_tready   m_tdata = read_data, written_count
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data (image width/height)
//
// Plot writes its pixel in setup if visible; read waits on the memory read;
// rectangle writes each clipped pixel in turn; line runs a radix-2 divider for
// the increments, then visits step+1 positions and writes each visible one;
// step zero skips the divider. One command is in flight at a time; the result
// waits in the output register while the next command is accepted. No memory
// clearing at reset: pixel contents are undefined until written.
// ----------------------------------------------------------------------------
module framebuffer_line_rect_drawer_core
    import fblrd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TD_IN_W-1:0]  s_tdata,   // x_a, y_a, x_b, y_b, color
    input  logic [FUNC_W-1:0]   s_tuser,   // func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TD_OUT_W-1:0] m_tdata,   // read_data, written_count, zero pad
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_RDWAIT,
        S_LPREP,
        S_DIV,
        S_LINC,
        S_LINE,
        S_RECT,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] cfg_w_reg, cfg_h_reg;

    func_t                      func_reg;
    logic signed [COORD_W-1:0]  xa_reg, ya_reg, xb_reg, yb_reg;
    logic [PIXEL_BITS-1:0]      color_reg;
    logic signed [DW-1:0]       dx_reg, dy_reg;

    logic [COORD_W-1:0]         step_reg, i_reg;
    logic                       sx_reg, sy_reg;
    logic [COORD_W:0]           rem_x_reg, rem_y_reg;
    logic [Q_W-1:0]             qx_reg, qy_reg;
    logic [DCW-1:0]             div_cnt_reg;
    logic signed [INC_W-1:0]    inc_x_reg, inc_y_reg;
    logic signed [POS_W-1:0]    px_reg, py_reg;

    logic [XW-1:0]              rx_reg, rx_lo_reg, rx_last_reg;
    logic [YW-1:0]              ry_reg, ry_last_reg;

    logic [CNT_W-1:0]           cnt_reg;
    logic [PIXEL_BITS-1:0]      data_reg;
    logic                       m_valid_reg;
    logic [TD_OUT_W-1:0]        m_tdata_reg;

    logic [PIXEL_BITS-1:0]      mem [DEPTH];
    logic [PIXEL_BITS-1:0]      mem_q_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;

    logic                       s_accept;
    logic [CW-1:0]              vis_w, vis_h;
    coord_t                     xa_c, ya_c, xb_c, yb_c;
    logic                       pt_inb;
    coord_t                     xl, yl, xh_raw, yh_raw, xh, yh, xh_m1, yh_m1;
    logic                       rect_ok;
    logic signed [DW-1:0]       ax_s, ay_s;
    logic [COORD_W-1:0]         ax, ay, step_c;
    logic                       ge_x, ge_y;
    logic [COORD_W:0]           rsub_x, rsub_y;
    coord_t                     tx, ty;
    logic                       ln_inb;
    logic                       rect_end;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // visible area, saturated to the store size
    assign vis_w = (CW'(cfg_w_reg) > CW'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(cfg_w_reg);
    assign vis_h = (CW'(cfg_h_reg) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(cfg_h_reg);

    assign xa_c   = coord_t'(xa_reg);
    assign ya_c   = coord_t'(ya_reg);
    assign xb_c   = coord_t'(xb_reg);
    assign yb_c   = coord_t'(yb_reg);
    assign pt_inb = in_bounds(xa_c, ya_c, vis_w, vis_h);

    // rectangle clip
    assign xl      = xa_c[CW-1] ? '0 : xa_c;
    assign yl      = ya_c[CW-1] ? '0 : ya_c;
    assign xh_raw  = xa_c + xb_c;
    assign yh_raw  = ya_c + yb_c;
    assign xh      = (xh_raw > $signed(vis_w)) ? $signed(vis_w) : xh_raw;
    assign yh      = (yh_raw > $signed(vis_h)) ? $signed(vis_h) : yh_raw;
    assign xh_m1   = xh - coord_t'(1);
    assign yh_m1   = yh - coord_t'(1);
    assign rect_ok = (xl < xh) && (yl < yh);

    // line setup
    assign ax_s   = dx_reg[DW-1] ? -dx_reg : dx_reg;
    assign ay_s   = dy_reg[DW-1] ? -dy_reg : dy_reg;
    assign ax     = ax_s[COORD_W-1:0];
    assign ay     = ay_s[COORD_W-1:0];
    assign step_c = (ax > ay) ? ax : ay;

    // one quotient bit per cycle for each axis
    assign ge_x   = rem_x_reg >= {1'b0, step_reg};
    assign ge_y   = rem_y_reg >= {1'b0, step_reg};
    assign rsub_x = ge_x ? rem_x_reg - {1'b0, step_reg} : rem_x_reg;
    assign rsub_y = ge_y ? rem_y_reg - {1'b0, step_reg} : rem_y_reg;

    assign tx     = q16_trunc(px_reg);
    assign ty     = q16_trunc(py_reg);
    assign ln_inb = in_bounds(tx, ty, vis_w, vis_h);

    assign rect_end = (rx_reg == rx_last_reg) && (ry_reg == ry_last_reg);

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = pix_addr(xa_reg[XW-1:0], ya_reg[YW-1:0]);
        case (state_reg)
            S_SETUP: begin
                mem_we = (func_reg == FUNC_PLOT) && pt_inb;
            end
            S_RECT: begin
                mem_we   = 1'b1;
                mem_addr = pix_addr(rx_reg, ry_reg);
            end
            S_LINE: begin
                mem_we   = ln_inb;
                mem_addr = pix_addr(tx[XW-1:0], ty[YW-1:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= color_reg;
        end
        mem_q_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= CFG_RESET;
            cfg_h_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_h_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) state_reg <= S_SETUP;
                end
                S_SETUP: begin
                    case (func_reg)
                        FUNC_LINE: state_reg <= S_LPREP;
                        FUNC_RECT: state_reg <= rect_ok ? S_RECT : S_DONE;
                        FUNC_READ: state_reg <= S_RDWAIT;
                        default:   state_reg <= S_DONE;
                    endcase
                end
                S_RDWAIT: state_reg <= S_DONE;
                S_LPREP: begin
                    state_reg <= (step_c == '0) ? S_LINE : S_DIV;
                end
                S_DIV: begin
                    if (div_cnt_reg == '0) state_reg <= S_LINC;
                end
                S_LINC: state_reg <= S_LINE;
                S_LINE: begin
                    if (i_reg == step_reg) state_reg <= S_DONE;
                end
                S_RECT: begin
                    if (rect_end) state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_tdata_reg <= {{(TD_OUT_W-CNT_W-PIXEL_BITS){1'b0}}, cnt_reg, data_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    func_reg  <= func_t'(s_tuser);
                    xa_reg    <= s_tdata[0 +: COORD_W];
                    ya_reg    <= s_tdata[COORD_W +: COORD_W];
                    xb_reg    <= s_tdata[2*COORD_W +: COORD_W];
                    yb_reg    <= s_tdata[3*COORD_W +: COORD_W];
                    color_reg <= s_tdata[4*COORD_W +: PIXEL_BITS];
                    dx_reg    <= DW'($signed(s_tdata[2*COORD_W +: COORD_W]))
                               - DW'($signed(s_tdata[0 +: COORD_W]));
                    dy_reg    <= DW'($signed(s_tdata[3*COORD_W +: COORD_W]))
                               - DW'($signed(s_tdata[COORD_W +: COORD_W]));
                    cnt_reg   <= '0;
                    data_reg  <= '0;
                end
            end
            S_SETUP: begin
                if (func_reg == FUNC_PLOT) begin
                    cnt_reg <= CNT_W'(pt_inb);
                end
                rx_reg      <= xl[XW-1:0];
                rx_lo_reg   <= xl[XW-1:0];
                rx_last_reg <= xh_m1[XW-1:0];
                ry_reg      <= yl[YW-1:0];
                ry_last_reg <= yh_m1[YW-1:0];
            end
            S_RDWAIT: begin
                data_reg <= pt_inb ? mem_q_reg : '0;
            end
            S_LPREP: begin
                step_reg    <= step_c;
                sx_reg      <= dx_reg[DW-1];
                sy_reg      <= dy_reg[DW-1];
                rem_x_reg   <= {1'b0, ax};
                rem_y_reg   <= {1'b0, ay};
                qx_reg      <= '0;
                qy_reg      <= '0;
                div_cnt_reg <= DCW'(DIV_STEPS - 1);
                inc_x_reg   <= '0;
                inc_y_reg   <= '0;
                px_reg      <= POS_W'($signed({xa_reg, {FRAC_W{1'b0}}}));
                py_reg      <= POS_W'($signed({ya_reg, {FRAC_W{1'b0}}}));
                i_reg       <= '0;
            end
            S_DIV: begin
                rem_x_reg   <= {rsub_x[COORD_W-1:0], 1'b0};
                rem_y_reg   <= {rsub_y[COORD_W-1:0], 1'b0};
                qx_reg      <= {qx_reg[Q_W-2:0], ge_x};
                qy_reg      <= {qy_reg[Q_W-2:0], ge_y};
                div_cnt_reg <= div_cnt_reg - DCW'(1);
            end
            S_LINC: begin
                inc_x_reg <= sx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                inc_y_reg <= sy_reg ? -$signed({1'b0, qy_reg}) : $signed({1'b0, qy_reg});
            end
            S_LINE: begin
                if (ln_inb) cnt_reg <= sat_inc(cnt_reg);
                px_reg <= px_reg + POS_W'(inc_x_reg);
                py_reg <= py_reg + POS_W'(inc_y_reg);
                i_reg  <= i_reg + COORD_W'(1);
            end
            S_RECT: begin
                cnt_reg <= sat_inc(cnt_reg);
                if (rx_reg == rx_last_reg) begin
                    rx_reg <= rx_lo_reg;
                    ry_reg <= ry_reg + YW'(1);
                end else begin
                    rx_reg <= rx_reg + XW'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/fblrd_checker.sv
// ----------------------------------------------------------------------------
// fblrd_checker
// Port-level checks on the drawer core: result holding under backpressure
// and one-command-at-a-time sequencing.
// ----------------------------------------------------------------------------
module fblrd_checker
    import fblrd_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [TD_OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready after a transaction");

    a_ready_drop_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input ready dropped without a transaction");

    a_result_ends_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && $past(!s_tready))
        else $error("result appeared outside command completion");

endmodule

bind framebuffer_line_rect_drawer_core fblrd_checker u_fblrd_checker (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for framebuffer_line_rect_drawer_core. Directed corner
// commands, then random line, fill, plot and read traffic under several
// clip sizes. A local raster model with its own frame copy predicts every
// result, and the results are compared field by field. Both stream sides
// stall at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import fblrd_pkg::*;

    typedef struct packed {
        func_t              func;
        logic signed [11:0] xa;
        logic signed [11:0] ya;
        logic signed [11:0] xb;
        logic signed [11:0] yb;
        logic [31:0]        color;
    } draw_cmd_t;

    typedef struct packed {
        logic [31:0]      pixel;
        logic [CNT_W-1:0] count;
    } px_result_t;

    localparam int HOLD_AT  = 30;
    localparam int HOLD_LEN = 400;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TD_IN_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]   s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [TD_OUT_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data  = '0;

    draw_cmd_t  cmd_backlog [$];
    px_result_t results_due [$];
    draw_cmd_t  cur_cmd;

    logic [31:0] fb_shadow [DEPTH];
    bit          px_known  [DEPTH];
    int          known_addrs [$];

    int vis_w = MAX_WIDTH;
    int vis_h = MAX_HEIGHT;

    int n_queued   = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 1;
    int n_by_func [4];
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    wire calm = (n_accepted >= 60) && (n_accepted < 90);

    framebuffer_line_rect_drawer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Raster model
    // ------------------------------------------------------------------
    function automatic bit on_screen(int x, int y);
        return x >= 0 && x < vis_w && y >= 0 && y < vis_h;
    endfunction

    function automatic int q16_to_px(longint p);
        return (p >= 0) ? int'(p >>> 16) : -int'((-p) >>> 16);
    endfunction

    function automatic int shade_px(int x, int y, logic [31:0] color);
        if (!on_screen(x, y)) begin
            return 0;
        end
        fb_shadow[y * MAX_WIDTH + x] = color;
        return 1;
    endfunction

    function automatic px_result_t predict_cmd(draw_cmd_t c);
        px_result_t r;
        int xa, ya, xb, yb, dx, dy, ax, ay, steps, n, i, x, y, xl, yl, xh, yh;
        longint fx, fy, ix, iy;
        r  = '0;
        n  = 0;
        xa = int'($signed(c.xa));
        ya = int'($signed(c.ya));
        xb = int'($signed(c.xb));
        yb = int'($signed(c.yb));
        n_by_func[c.func]++;
        case (c.func)
            FUNC_LINE: begin
                dx = xb - xa;
                dy = yb - ya;
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                steps = ax > ay ? ax : ay;
                ix = 0;
                iy = 0;
                if (steps > 0) begin
                    ix = (longint'(dx) * 65536) / steps;
                    iy = (longint'(dy) * 65536) / steps;
                end
                fx = longint'(xa) * 65536;
                fy = longint'(ya) * 65536;
                for (i = 0; i <= steps; i++) begin
                    n += shade_px(q16_to_px(fx), q16_to_px(fy), c.color);
                    fx += ix;
                    fy += iy;
                end
            end
            FUNC_RECT: begin
                xl = xa < 0 ? 0 : xa;
                yl = ya < 0 ? 0 : ya;
                xh = (xa + xb > vis_w) ? vis_w : xa + xb;
                yh = (ya + yb > vis_h) ? vis_h : ya + yb;
                for (y = yl; y < yh; y++) begin
                    for (x = xl; x < xh; x++) begin
                        n += shade_px(x, y, c.color);
                    end
                end
            end
            FUNC_READ: begin
                if (on_screen(xa, ya)) begin
                    r.pixel = fb_shadow[ya * MAX_WIDTH + xa];
                end
            end
            default: begin
                n = shade_px(xa, ya, c.color);
            end
        endcase
        if (n > int'(COUNT_MAX)) begin
            n = int'(COUNT_MAX);
        end
        r.count = CNT_W'(n);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(predict_cmd(cur_cmd));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    s_tdata <= {cur_cmd.color, cur_cmd.yb, cur_cmd.xb, cur_cmd.ya,
                                cur_cmd.xa};
                    s_tuser <= cur_cmd.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: backpressure and checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        px_result_t  want;
        logic [31:0]      got_pixel;
        logic [CNT_W-1:0] got_count;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                m_tready  <= 1'b0;
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 6);
            end

            if (m_tvalid && m_tready) begin
                got_pixel = m_tdata[31:0];
                got_count = m_tdata[32 +: CNT_W];
                if (results_due.size() == 0) begin
                    $error("unexpected result: read_data %h written_count %0d",
                           got_pixel, got_count);
                    n_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (got_pixel !== want.pixel) begin
                        $error("read_data: expected %h, got %h", want.pixel, got_pixel);
                        n_errors++;
                    end
                    if (got_count !== want.count) begin
                        $error("written_count: expected %0d, got %0d",
                               want.count, got_count);
                        n_errors++;
                    end
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void note_written(int x, int y);
        int a;
        a = y * MAX_WIDTH + x;
        if (!px_known[a]) begin
            px_known[a] = 1'b1;
            known_addrs.push_back(a);
        end
    endfunction

    task automatic add_cmd(func_t f, int xa, int ya, int xb, int yb, logic [31:0] color);
        draw_cmd_t c;
        int xl, yl;
        c.func  = f;
        c.xa    = 12'(xa);
        c.ya    = 12'(ya);
        c.xb    = 12'(xb);
        c.yb    = 12'(yb);
        c.color = color;
        // track pixels guaranteed written so reads never hit fresh memory
        if ((f == FUNC_PLOT || f == FUNC_LINE) && on_screen(xa, ya)) begin
            note_written(xa, ya);
        end
        if (f == FUNC_RECT) begin
            xl = xa < 0 ? 0 : xa;
            yl = ya < 0 ? 0 : ya;
            if (xl < xa + xb && yl < ya + yb && on_screen(xl, yl)) begin
                note_written(xl, yl);
            end
        end
        cmd_backlog.push_back(c);
        n_queued++;
    endtask

    function automatic int any_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int near_axis(int extent);
        return int'($urandom_range(extent + 31)) - 16;
    endfunction

    task automatic queue_random(int count);
        int roll, x, y, xb, yb, a;
        bit wide;
        repeat (count) begin
            roll = $urandom_range(99);
            wide = ($urandom_range(99) < 20);
            xb   = any_coord();
            yb   = any_coord();
            if (roll < 30) begin
                if (wide) begin
                    add_cmd(FUNC_LINE, any_coord(), any_coord(), xb, yb, $urandom);
                end else begin
                    add_cmd(FUNC_LINE, near_axis(vis_w), near_axis(vis_h),
                            near_axis(vis_w), near_axis(vis_h), $urandom);
                end
            end else if (roll < 50) begin
                if ($urandom_range(99) < 10) begin
                    add_cmd(FUNC_RECT, any_coord(), any_coord(), xb, yb, $urandom);
                end else begin
                    add_cmd(FUNC_RECT, near_axis(vis_w), near_axis(vis_h),
                            int'($urandom_range(vis_w / 2 + 6)) - 4,
                            int'($urandom_range(vis_h / 2 + 6)) - 4, $urandom);
                end
            end else if (roll < 75) begin
                if (known_addrs.size() != 0 && $urandom_range(99) < 60) begin
                    a = known_addrs[$urandom_range(known_addrs.size() - 1)];
                    x = a % MAX_WIDTH;
                    y = a / MAX_WIDTH;
                end else begin
                    x = wide ? any_coord() : near_axis(vis_w);
                    y = wide ? any_coord() : near_axis(vis_h);
                    if (on_screen(x, y) && !px_known[y * MAX_WIDTH + x]) begin
                        if (known_addrs.size() != 0) begin
                            a = known_addrs[$urandom_range(known_addrs.size() - 1)];
                            x = a % MAX_WIDTH;
                            y = a / MAX_WIDTH;
                        end else begin
                            x = -1;
                        end
                    end
                end
                add_cmd(FUNC_READ, x, y, xb, yb, $urandom);
            end else begin
                x = wide ? any_coord() : near_axis(vis_w);
                y = wide ? any_coord() : near_axis(vis_h);
                add_cmd(FUNC_PLOT, x, y, xb, yb, $urandom);
            end
        end
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            vis_w = (val > MAX_WIDTH) ? MAX_WIDTH : val;
        end else begin
            vis_h = (val > MAX_HEIGHT) ? MAX_HEIGHT : val;
        end
        @(posedge aclk);
    endtask

    task automatic run_phase(int w, int h, int count);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        n_settings++;
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        foreach (fb_shadow[i]) begin
            fb_shadow[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_cmd(FUNC_PLOT, 0, 0, 0, 0, 32'hFFFF_FFFF);
        add_cmd(FUNC_PLOT, 127, 127, 2047, -2048, 32'h0);
        add_cmd(FUNC_PLOT, -1, 5, 0, 0, $urandom);
        add_cmd(FUNC_PLOT, 128, 0, 0, 0, $urandom);
        add_cmd(FUNC_PLOT, 2047, -2048, 0, 0, $urandom);
        add_cmd(FUNC_READ, 0, 0, 0, 0, 32'h0);
        add_cmd(FUNC_READ, 127, 127, 0, 0, 32'h0);
        add_cmd(FUNC_READ, -2048, 2047, -1, -1, 32'hFFFF_FFFF);
        add_cmd(FUNC_LINE, 10, 10, 10, 10, 32'hA5A5_A5A5);
        add_cmd(FUNC_LINE, 0, 0, 127, 127, $urandom);
        add_cmd(FUNC_LINE, -2048, -2048, 2047, 2047, $urandom);
        add_cmd(FUNC_LINE, 0, -1, 2, 0, $urandom);
        add_cmd(FUNC_LINE, 100, 50, 20, 10, $urandom);
        add_cmd(FUNC_LINE, 2047, 0, -2048, 5, $urandom);
        add_cmd(FUNC_RECT, 0, 0, 128, 128, 32'h1234_5678);
        add_cmd(FUNC_RECT, -2048, -2048, 2047, 2047, $urandom);
        add_cmd(FUNC_RECT, 10, 10, 0, 5, $urandom);
        add_cmd(FUNC_RECT, 10, 10, 5, -2048, $urandom);
        add_cmd(FUNC_RECT, 120, 120, 2047, 2047, $urandom);
        add_cmd(FUNC_RECT, -5, -5, 10, 10, $urandom);
        add_cmd(FUNC_READ, 64, 64, 0, 0, 32'h0);
        add_cmd(FUNC_READ, 125, 125, 0, 0, 32'h0);
        add_cmd(FUNC_PLOT, 5, 5, 0, 0, 32'hDEAD_BEEF);
        add_cmd(FUNC_READ, 5, 5, 0, 0, 32'h0);
        wait_drained();

        run_phase(255, 200, 20);
        run_phase(1, 1, 8);
        run_phase(0, 77, 4);
        run_phase(128, 0, 4);
        run_phase(45, 20, 20);
        run_phase(128, 128, 20);

        repeat (50) @(posedge aclk);
        $display("Ran %0d commands (%0d lines, %0d fills, %0d reads, %0d plots)",
                 n_accepted, n_by_func[FUNC_LINE], n_by_func[FUNC_RECT],
                 n_by_func[FUNC_READ], n_by_func[FUNC_PLOT]);
        $display("across %0d clip sizes, %0d results compared", n_settings, n_checked);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
rtl/fblrd_pkg.sv
rtl/framebuffer_line_rect_drawer_core.sv
rtl/fblrd_checker.sv
dv/testbench.sv
